@@ design/pwsr_pkg.sv @@
// Package for the phased weight-shift ramp: constants, codes, shared types.
// No dependencies.
package pwsr_pkg;

    localparam int TORSO_SHIFT_CDEG = 0;

    localparam logic [3:0] REG_RAMP  = 4'd0;
    localparam logic [3:0] REG_DELAY = 4'd1;
    localparam logic [3:0] REG_DWELL = 4'd2;
    localparam logic [3:0] REG_ANKLE = 4'd3;
    localparam logic [3:0] REG_SP    = 4'd4;
    localparam logic [3:0] REG_LEAN  = 4'd5;
    localparam logic [3:0] REG_ALPHA = 4'd6;
    localparam logic [3:0] REG_LAT   = 4'd7;

    localparam logic [1:0] DIR_CENTRE = 2'd0;
    localparam logic [1:0] DIR_LEFT   = 2'd1;
    localparam logic [1:0] DIR_RIGHT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_ADV,
        ST_SP,
        ST_RAW,
        ST_IIR_A,
        ST_IIR_B,
        ST_BIAS_R,
        ST_BIAS_L,
        ST_LAT,
        ST_DONE
    } state_t;

    // round(v / 2^sh), ties away from zero, v a 48-bit product
    function automatic logic signed [47:0] rshift_round(input logic signed [47:0] v,
                                                        input logic [4:0] sh);
        logic [47:0] mag;
        logic [47:0] half;
        logic [47:0] q;
        begin
            mag  = v[47] ? 48'(-v) : 48'(v);
            half = 48'd1 << (sh - 5'd1);
            q    = (mag + half) >> sh;
            rshift_round = v[47] ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic logic signed [47:0] sat_w(input logic signed [47:0] v,
                                                 input logic [4:0] w);
        logic signed [47:0] hi;
        logic signed [47:0] lo;
        begin
            hi = $signed((48'd1 << (w - 5'd1)) - 48'd1);
            lo = -$signed(48'd1 << (w - 5'd1));
            sat_w = (v > hi) ? hi : ((v < lo) ? lo : v);
        end
    endfunction

endpackage

@@ design/pwsr_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pwsr_pkg.
module pwsr_div
    import pwsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [29:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [29:0] quotient
);
    logic [29:0] q_reg, q_next;
    logic [24:0] r_reg, r_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[23:0], q_reg[29]};
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            cnt_next  = 5'd29;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                r_next = trial - {1'b0, divisor};
                q_next = {q_reg[28:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[28:0], 1'b0};
            end
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
                cnt_next = cnt_reg - 5'd1;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

@@ design/pwsr_mul.sv @@
// Shared 24x24 multiplier with registered product.
// Depends on pwsr_pkg.
module pwsr_mul
    import pwsr_pkg::*;
(
    input  logic               clk,
    input  logic signed [23:0] a,
    input  logic signed [23:0] b,
    output logic signed [47:0] p
);
    logic signed [47:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

@@ design/phased_weight_shift_ramp.sv @@
// Phased weight-shift ramp top: registers, state, sequencer, result register.
// Depends on pwsr_pkg, pwsr_div, pwsr_mul.
// A tick runs the divider, an advance step, seven multiplier passes pipelined one per
// cycle and a finish step; a trigger goes from the advance step to the bias passes,
// a stopped tick straight to them. One beat at a time: in_ready is low until the
// result beat is taken. Async active-low reset clears state and config (ramp to 300).
module phased_weight_shift_ramp
    import pwsr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [18:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [1:0]         direction,
    input  logic [15:0]        dt_us,
    input  logic [31:0]        now_ms,
    input  logic               estop,
    input  logic               right_leg,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] right_ankle_prog,
    output logic signed [15:0] left_ankle_prog,
    output logic               ramping,
    output logic signed [12:0] bias_right_cdeg,
    output logic signed [12:0] bias_left_cdeg,
    output logic signed [18:0] roll_setpoint_urad,
    output logic               setpoint_changed,
    output logic signed [16:0] forward_offset_um,
    output logic signed [16:0] lateral_offset_um,
    output logic signed [14:0] torso_roll_cdeg,
    output logic               torso_valid,
    output logic               trigger_ignored
);
    // configuration registers
    logic [13:0]        ramp_reg;
    logic [10:0]        delay_reg;
    logic [12:0]        dwell_reg;
    logic signed [12:0] ankle_reg;
    logic signed [18:0] sp_reg;
    logic [15:0]        lean_reg;
    logic [15:0]        alpha_reg;
    logic signed [16:0] lat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_reg  <= 14'd300;
            delay_reg <= '0;
            dwell_reg <= '0;
            ankle_reg <= '0;
            sp_reg    <= '0;
            lean_reg  <= '0;
            alpha_reg <= '0;
            lat_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RAMP:  ramp_reg  <= cfg_data[13:0];
                REG_DELAY: delay_reg <= cfg_data[10:0];
                REG_DWELL: dwell_reg <= cfg_data[12:0];
                REG_ANKLE: ankle_reg <= cfg_data[12:0];
                REG_SP:    sp_reg    <= cfg_data;
                REG_LEAN:  lean_reg  <= cfg_data[15:0];
                REG_ALPHA: alpha_reg <= cfg_data[15:0];
                REG_LAT:   lat_reg   <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    // block state
    state_t             state_reg, state_next;
    logic [1:0]         dir_reg, dir_next;
    logic signed [15:0] rp_reg, rp_next, lp_reg, lp_next;
    logic signed [1:0]  rt_reg, rt_next, lt_reg, lt_next;
    logic [20:0]        rd_reg, rd_next, ld_reg, ld_next;
    logic signed [18:0] lsp_reg, lsp_next;
    logic [31:0]        settled_reg, settled_next;
    logic [16:0]        smooth_reg, smooth_next;
    logic [47:0]        acc_reg, acc_next;
    logic               out_valid_reg, out_valid_next;

    // latched beat
    logic        act_reg, act_next;
    logic [1:0]  idir_reg, idir_next;
    logic [15:0] dt_reg, dt_next;
    logic [31:0] now_reg, now_next;
    logic        stop_reg, stop_next;
    logic        leg_reg, leg_next;

    // result fields
    logic               ramping_reg, ramping_next;
    logic signed [12:0] br_reg, br_next, bl_reg, bl_next;
    logic               chg_reg, chg_next;
    logic signed [16:0] lato_reg, lato_next;
    logic signed [14:0] torso_reg, torso_next;
    logic               tv_reg, tv_next;
    logic               ign_reg, ign_next;

    // shared units
    logic               div_start;
    logic               div_done;
    logic [29:0]        quot;
    logic [13:0]        ramp_eff;
    logic signed [23:0] ma, mb;
    logic signed [47:0] prod;

    assign ramp_eff = (ramp_reg < 14'd10) ? 14'd10 : ramp_reg;

    // dividend comes from the beat being accepted, captured with start
    pwsr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({dt_next, 14'd0}),
        .divisor  (24'(ramp_eff) * 24'd1000),
        .done     (div_done),
        .quotient (quot)
    );

    pwsr_mul u_mul (
        .clk (clk),
        .a   (ma),
        .b   (mb),
        .p   (prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dir_reg       <= DIR_CENTRE;
            rp_reg        <= '0;
            lp_reg        <= '0;
            rt_reg        <= '0;
            lt_reg        <= '0;
            rd_reg        <= '0;
            ld_reg        <= '0;
            lsp_reg       <= '0;
            settled_reg   <= '0;
            smooth_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            dir_reg       <= dir_next;
            rp_reg        <= rp_next;
            lp_reg        <= lp_next;
            rt_reg        <= rt_next;
            lt_reg        <= lt_next;
            rd_reg        <= rd_next;
            ld_reg        <= ld_next;
            lsp_reg       <= lsp_next;
            settled_reg   <= settled_next;
            smooth_reg    <= smooth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg     <= acc_next;
        act_reg     <= act_next;
        idir_reg    <= idir_next;
        dt_reg      <= dt_next;
        now_reg     <= now_next;
        stop_reg    <= stop_next;
        leg_reg     <= leg_next;
        ramping_reg <= ramping_next;
        br_reg      <= br_next;
        bl_reg      <= bl_next;
        chg_reg     <= chg_next;
        lato_reg    <= lato_next;
        torso_reg   <= torso_next;
        tv_reg      <= tv_next;
        ign_reg     <= ign_next;
    end

    logic signed [16:0] sum;
    logic [16:0]        sum_abs;
    logic [18:0]        sp_abs;
    logic signed [47:0] rnd;
    logic signed [16:0] rdiff, ldiff;
    logic [15:0]        step;
    logic signed [18:0] newsp;
    logic signed [19:0] spd;
    logic [1:0]         ndir;
    logic [31:0]        since;
    logic               rdy_i;
    logic signed [47:0] torso_prod;
    logic               torso_on;

    assign sum     = 17'(rp_reg) + 17'(lp_reg);
    assign sum_abs = sum[16] ? 17'(-sum) : 17'(sum);
    assign sp_abs  = sp_reg[18] ? 19'(-sp_reg) : 19'(sp_reg);
    assign step    = (quot[29:16] != '0) ? 16'hFFFF : quot[15:0];
    assign rdiff   = 17'(rt_reg) * 17'sd16384 - 17'(rp_reg);
    assign ldiff   = 17'(lt_reg) * 17'sd16384 - 17'(lp_reg);
    assign since   = now_reg - settled_reg;
    assign ndir    = (idir_reg == 2'd3) ? DIR_RIGHT : idir_reg;
    assign rdy_i   = (state_reg == ST_IDLE) && !out_valid_reg;

    // torso command: constant amplitude, so a fixed product off the progress sum
    assign torso_prod = 48'(sum) * 48'(TORSO_SHIFT_CDEG);
    assign torso_on   = (TORSO_SHIFT_CDEG > 1 || TORSO_SHIFT_CDEG < -1) &&
                        (sum_abs > 17'd327);

    // progress after one advance step
    function automatic logic signed [15:0] adv(input logic signed [15:0] p,
                                               input logic signed [16:0] d,
                                               input logic [15:0] st);
        logic [16:0] m;
        begin
            m = d[16] ? 17'(-d) : 17'(d);
            if (m <= {1'b0, st})
                adv = 16'(p + d);
            else if (d[16])
                adv = 16'(p - $signed({1'b0, st}));
            else
                adv = 16'(p + $signed({1'b0, st}));
        end
    endfunction

    function automatic logic is_ramp(input logic signed [16:0] rd,
                                     input logic signed [16:0] ld,
                                     input logic [20:0] rdl,
                                     input logic [20:0] ldl);
        begin
            is_ramp = (rd > 17'sd16) || (rd < -17'sd16) || (ld > 17'sd16) ||
                      (ld < -17'sd16) || (rdl != '0) || (ldl != '0);
        end
    endfunction

    always_comb
    begin
        state_next     = state_reg;
        dir_next       = dir_reg;
        rp_next        = rp_reg;
        lp_next        = lp_reg;
        rt_next        = rt_reg;
        lt_next        = lt_reg;
        rd_next        = rd_reg;
        ld_next        = ld_reg;
        lsp_next       = lsp_reg;
        settled_next   = settled_reg;
        smooth_next    = smooth_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        act_next       = act_reg;
        idir_next      = idir_reg;
        dt_next        = dt_reg;
        now_next       = now_reg;
        stop_next      = stop_reg;
        leg_next       = leg_reg;
        ramping_next   = ramping_reg;
        br_next        = br_reg;
        bl_next        = bl_reg;
        chg_next       = chg_reg;
        lato_next      = lato_reg;
        torso_next     = torso_reg;
        tv_next        = tv_reg;
        ign_next       = ign_reg;
        div_start      = 1'b0;
        ma             = '0;
        mb             = '0;
        rnd            = '0;
        newsp          = '0;
        spd            = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && rdy_i)
                begin
                    act_next  = action;
                    idir_next = direction;
                    dt_next   = dt_us;
                    now_next  = now_ms;
                    stop_next = estop;
                    leg_next  = right_leg;
                    chg_next  = 1'b0;
                    ign_next  = 1'b0;
                    if (action || estop)
                        state_next = ST_BIAS_R;
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    if (action)
                        state_next = ST_ADV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_ADV;
            end
            ST_ADV:
            begin
                if (act_reg)
                begin
                    if (ndir != DIR_CENTRE && dir_reg != DIR_CENTRE && ndir != dir_reg &&
                        dwell_reg != '0 && settled_reg != '0 &&
                        since < 32'(dwell_reg))
                        ign_next = 1'b1;
                    else
                    begin
                        settled_next = '0;
                        dir_next     = ndir;
                        rd_next      = '0;
                        ld_next      = '0;
                        if (ndir == DIR_CENTRE)
                        begin
                            rt_next = 2'sd0;
                            lt_next = 2'sd0;
                        end
                        else if (ndir == DIR_LEFT)
                        begin
                            rt_next = 2'sd1;
                            lt_next = 2'sd1;
                            ld_next = 21'(delay_reg) * 21'd1000;
                        end
                        else
                        begin
                            rt_next = -2'sd1;
                            lt_next = -2'sd1;
                            rd_next = 21'(delay_reg) * 21'd1000;
                        end
                    end
                    state_next = ST_BIAS_R;
                end
                else
                begin
                    if (rd_reg != '0)
                        rd_next = (rd_reg > 21'(dt_reg)) ? rd_reg - 21'(dt_reg) : '0;
                    else
                        rp_next = adv(rp_reg, rdiff, step);
                    if (ld_reg != '0)
                        ld_next = (ld_reg > 21'(dt_reg)) ? ld_reg - 21'(dt_reg) : '0;
                    else
                        lp_next = adv(lp_reg, ldiff, step);
                    state_next = ST_SP;
                end
            end
            ST_SP:
            begin
                // progress registers updated; settle check and setpoint product
                if (!is_ramp(rdiff, ldiff, rd_reg, ld_reg) && settled_reg == '0 &&
                    dir_reg != DIR_CENTRE)
                    settled_next = now_reg;
                ma         = 24'(sum);
                mb         = 24'($signed({1'b0, sp_abs}));
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                rnd   = sat_w(-rshift_round(prod, 5'd15), 5'd19);
                newsp = 19'(rnd);
                spd   = 20'(newsp) - 20'(lsp_reg);
                if (spd > 20'sd500 || spd < -20'sd500)
                begin
                    lsp_next = newsp;
                    chg_next = 1'b1;
                end
                ma         = 24'($signed({1'b0, sum_abs}));
                mb         = 24'($signed({1'b0, lean_reg}));
                state_next = ST_IIR_A;
            end
            ST_IIR_A:
            begin
                // prod holds |sum|*lean; keep raw in acc
                acc_next   = 48'(rshift_round(prod, 5'd15));
                ma         = 24'($signed({1'b0, alpha_reg}));
                mb         = 24'($signed({1'b0, smooth_reg}));
                state_next = ST_IIR_B;
            end
            ST_IIR_B:
            begin
                // 65536 - alpha needs 17 bits, kept positive
                acc_next   = 48'(prod) + 48'd32768;
                ma         = {7'd0, 17'h10000 - {1'b0, alpha_reg}};
                mb         = 24'(acc_reg);
                state_next = ST_BIAS_R;
            end
            ST_BIAS_R:
            begin
                if (!act_reg && !stop_reg)
                    smooth_next = 17'((acc_reg + 48'(prod)) >> 16);
                ma         = 24'(rp_reg);
                mb         = 24'(ankle_reg);
                state_next = ST_BIAS_L;
            end
            ST_BIAS_L:
            begin
                br_next    = 13'(sat_w(-rshift_round(prod, 5'd14), 5'd13));
                ma         = 24'(lp_reg);
                mb         = 24'(ankle_reg);
                state_next = ST_LAT;
            end
            ST_LAT:
            begin
                bl_next    = 13'(sat_w(rshift_round(prod, 5'd14), 5'd13));
                ma         = 24'(sum);
                mb         = 24'(lat_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                rnd = sat_w(rshift_round(prod, 5'd15), 5'd17);
                if (!leg_reg)
                    rnd = -rnd;
                lato_next = 17'(sat_w(rnd, 5'd17));
                if (ankle_reg > 13'sd1 || ankle_reg < -13'sd1)
                    ;
                else
                begin
                    br_next = '0;
                    bl_next = '0;
                end
                // torso command only on a running tick past both deadbands
                if (!act_reg && !stop_reg && torso_on)
                begin
                    tv_next    = 1'b1;
                    torso_next = 15'(sat_w(rshift_round(torso_prod, 5'd15), 5'd15));
                end
                else
                begin
                    tv_next    = 1'b0;
                    torso_next = '0;
                end
                ramping_next   = is_ramp(rdiff, ldiff, rd_reg, ld_reg);
                out_valid_next = 1'b1;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign in_ready           = rdy_i;
    assign out_valid          = out_valid_reg;
    assign right_ankle_prog   = rp_reg;
    assign left_ankle_prog    = lp_reg;
    assign ramping            = ramping_reg;
    assign bias_right_cdeg    = br_reg;
    assign bias_left_cdeg     = bl_reg;
    assign roll_setpoint_urad = lsp_reg;
    assign setpoint_changed   = chg_reg;
    assign forward_offset_um  = stop_reg ? 17'sd0 :
                                ((smooth_reg[16]) ? $signed(17'h10000) : -$signed(smooth_reg));
    assign lateral_offset_um  = stop_reg ? 17'sd0 : lato_reg;
    assign torso_roll_cdeg    = torso_reg;
    assign torso_valid        = tv_reg;
    assign trigger_ignored    = ign_reg;
endmodule
